FILE: sv/dshs_pkg.sv
// Shared types and constants for the dual stepper homing sequencer.
// Used by the config register file, the motor core and the top level.
package dshs_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int FAULT_FLOOR       = 10;
  localparam int CFG_IDX_BITS      = 3;
  localparam int CFG_DATA_BITS     = 16;

  typedef enum logic [2:0] {
    CMD_STOP = 3'd0,
    CMD_FWD  = 3'd1,
    CMD_END  = 3'd2,
    CMD_BACK = 3'd3,
    CMD_ZERO = 3'd4
  } cmd_t;

  typedef enum logic [0:0] {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MAX_POS_A     = 3'd0,
    REG_MAX_POS_B     = 3'd1,
    REG_SLOW_ZONE     = 3'd2,
    REG_CONFIRM_COUNT = 3'd3,
    REG_HOME_POSITION = 3'd4,
    REG_BACKOFF_STEPS = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] max_position_a;
    logic [15:0] max_position_b;
    logic [15:0] slow_zone;
    logic [7:0]  switch_confirm_count;
    logic [15:0] home_position;
    logic [15:0] backoff_steps;
  } cfg_t;

  typedef struct packed {
    logic        opcode;
    logic        motor_select;
    logic [2:0]  command;
    logic [15:0] step_count;
    logic [1:0]  home_sw_n;
  } item_t;

  typedef struct packed {
    logic [1:0]  phase_a;
    logic [1:0]  phase_b;
    logic        enable_a;
    logic        enable_b;
    logic [2:0]  mode_a;
    logic [2:0]  mode_b;
    logic [15:0] position_a;
    logic [15:0] position_b;
    logic        home_fault;
  } result_t;

  function automatic logic [1:0] gray2(input logic [1:0] idx);
    logic [1:0] g;
    case (idx)
      2'd0:    g = 2'b00;
      2'd1:    g = 2'b01;
      2'd2:    g = 2'b11;
      2'd3:    g = 2'b10;
      default: g = 2'b00;
    endcase
    return g;
  endfunction

endpackage

FILE: sv/dshs_cfg_regs.sv
// Configuration register file for the dual stepper homing sequencer.
// Depends on dshs_pkg for register indexes and the cfg_t bundle.
module dshs_cfg_regs
  import dshs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output cfg_t                     cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_position_a       <= 16'd4000;
      cfg_r.max_position_b       <= 16'd4000;
      cfg_r.slow_zone            <= 16'd200;
      cfg_r.switch_confirm_count <= 8'd3;
      cfg_r.home_position        <= 16'd20;
      cfg_r.backoff_steps        <= 16'd50;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MAX_POS_A:     cfg_r.max_position_a       <= cfg_wdata;
        REG_MAX_POS_B:     cfg_r.max_position_b       <= cfg_wdata;
        REG_SLOW_ZONE:     cfg_r.slow_zone            <= cfg_wdata;
        REG_CONFIRM_COUNT: cfg_r.switch_confirm_count <= cfg_wdata[7:0];
        REG_HOME_POSITION: cfg_r.home_position        <= cfg_wdata;
        REG_BACKOFF_STEPS: cfg_r.backoff_steps        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/dshs_motor_core.sv
// Per-motor state and single-pass step logic for both motors.
// Depends on dshs_pkg; produces the result word for each applied item.
module dshs_motor_core
  import dshs_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  localparam int PW = POSITION_BITS;
  localparam int CW = (PW > 16) ? PW : 16;
  localparam logic [PW-1:0] POS_ONES = {PW{1'b1}};

  cmd_t          mode_r  [2];
  logic [15:0]   steps_r [2];
  logic [PW-1:0] pos_r   [2];
  logic [1:0]    idx_r   [2];
  logic          skip_r  [2];
  logic [7:0]    swc_r   [2];
  logic [1:0]    ph_r    [2];

  cmd_t          mode_nxt  [2];
  logic [15:0]   steps_nxt [2];
  logic [PW-1:0] pos_nxt   [2];
  logic [1:0]    idx_nxt   [2];
  logic          skip_nxt  [2];
  logic [7:0]    swc_nxt   [2];
  logic [1:0]    ph_nxt    [2];
  logic [1:0]    en;
  logic          fault;

  always_comb begin
    logic          m;
    cmd_t          mode;
    logic [15:0]   steps;
    logic [PW-1:0] pos;
    logic [CW-1:0] pos_c;
    logic [CW-1:0] limit_c;
    logic          go;
    logic [7:0]    cnt;

    for (int k = 0; k < 2; k++) begin
      mode_nxt[k]  = mode_r[k];
      steps_nxt[k] = steps_r[k];
      pos_nxt[k]   = pos_r[k];
      idx_nxt[k]   = idx_r[k];
      skip_nxt[k]  = skip_r[k];
      swc_nxt[k]   = swc_r[k];
      ph_nxt[k]    = ph_r[k];
    end
    en    = 2'b00;
    fault = 1'b0;

    m       = (mode_r[0] != CMD_STOP) ? 1'b0 : 1'b1;
    mode    = mode_r[m];
    steps   = steps_r[m];
    pos     = pos_r[m];
    pos_c   = CW'(pos);
    limit_c = m ? CW'(cfg.max_position_b) : CW'(cfg.max_position_a);
    go      = 1'b1;
    cnt     = swc_r[m];

    if (item.opcode == OP_LOAD) begin
      mode_nxt[item.motor_select]  = (item.command > CMD_ZERO) ? CMD_STOP
                                                               : cmd_t'(item.command);
      steps_nxt[item.motor_select] = item.step_count;
    end else begin
      case (mode)
        CMD_FWD, CMD_END: begin
          if (mode == CMD_END) begin
            steps = 16'hFFFF;
          end
          if (steps == 16'd0 || pos_c >= limit_c || pos == POS_ONES) begin
            steps_nxt[m] = 16'd0;
            mode_nxt[m]  = CMD_STOP;
          end else begin
            en[m]        = 1'b1;
            ph_nxt[m]    = gray2(idx_r[m]);
            idx_nxt[m]   = idx_r[m] + 2'd1;
            pos_nxt[m]   = pos + PW'(1);
            steps_nxt[m] = steps - 16'd1;
          end
        end
        CMD_BACK, CMD_ZERO: begin
          if (mode == CMD_BACK && steps == 16'd0) begin
            mode_nxt[m] = CMD_STOP;
            go          = 1'b0;
          end else if (pos < PW'(FAULT_FLOOR)) begin
            mode_nxt[m] = CMD_STOP;
            fault       = 1'b1;
            go          = 1'b0;
          end else if (pos_c < CW'(cfg.slow_zone)) begin
            skip_nxt[m] = ~skip_r[m];
            go          = ~skip_r[m];
          end
          if (go) begin
            if (!item.home_sw_n[m]) begin
              if (cnt != 8'hFF) begin
                cnt = cnt + 8'd1;
              end
            end else if (cnt != 8'd0) begin
              cnt = cnt - 8'd1;
            end
            swc_nxt[m] = cnt;
            if (cnt >= cfg.switch_confirm_count) begin
              swc_nxt[m]   = 8'd0;
              pos_nxt[m]   = PW'(cfg.home_position);
              mode_nxt[m]  = CMD_FWD;
              steps_nxt[m] = cfg.backoff_steps;
            end else begin
              en[m]      = 1'b1;
              ph_nxt[m]  = gray2(idx_r[m]);
              idx_nxt[m] = idx_r[m] - 2'd1;
              pos_nxt[m] = pos - PW'(1);
              if (mode == CMD_BACK) begin
                steps_nxt[m] = steps - 16'd1;
              end
            end
          end
        end
        default: mode_nxt[m] = CMD_STOP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 2; k++) begin
        mode_r[k]  <= CMD_STOP;
        steps_r[k] <= '0;
        pos_r[k]   <= '0;
        idx_r[k]   <= '0;
        skip_r[k]  <= 1'b0;
        swc_r[k]   <= '0;
        ph_r[k]    <= '0;
      end
    end else if (step) begin
      for (int k = 0; k < 2; k++) begin
        mode_r[k]  <= mode_nxt[k];
        steps_r[k] <= steps_nxt[k];
        pos_r[k]   <= pos_nxt[k];
        idx_r[k]   <= idx_nxt[k];
        skip_r[k]  <= skip_nxt[k];
        swc_r[k]   <= swc_nxt[k];
        ph_r[k]    <= ph_nxt[k];
      end
    end
  end

  logic [CW-1:0] pos_a_ext;
  logic [CW-1:0] pos_b_ext;

  assign pos_a_ext = CW'(pos_nxt[0]);
  assign pos_b_ext = CW'(pos_nxt[1]);

  assign res.phase_a    = ph_nxt[0];
  assign res.phase_b    = ph_nxt[1];
  assign res.enable_a   = en[0];
  assign res.enable_b   = en[1];
  assign res.mode_a     = mode_nxt[0];
  assign res.mode_b     = mode_nxt[1];
  assign res.position_a = pos_a_ext[15:0];
  assign res.position_b = pos_b_ext[15:0];
  assign res.home_fault = fault;

  a_one_motor: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> !(en[0] && en[1]))
    else $error("both motors enabled on one tick");

  a_fault_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && fault) |-> (en == 2'b00))
    else $error("fault flagged on a stepping tick");

  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.opcode == OP_LOAD) |-> (en == 2'b00 && !fault))
    else $error("load word drove coils or fault");

  a_step_moves_a: assert property (@(posedge clk) disable iff (!rst_n)
    (step && en[0]) |=> (pos_r[0] != $past(pos_r[0])))
    else $error("motor A stepped without moving");

endmodule

FILE: sv/dual_stepper_homing_sequencer_top.sv
// Top level of the dual stepper homing sequencer: input and result registers
// around dshs_motor_core, plus dshs_cfg_regs. Depends on dshs_pkg.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    opcode, motor_select, command, step_count, switches
//   out_     output     out_valid/out_ready  phases, enables, modes, positions, home_fault
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// Words go from the input register to the result register; one word per cycle unless stalled.
// Motor state updates as a word moves from the input register into the result register.
// A stalled result holds both registers; the input register still fills while empty.
// Synchronous active-low reset clears control, motor state and configuration.
module dual_stepper_homing_sequencer_top
  import dshs_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_opcode,
  input  logic                     in_motor_select,
  input  logic [2:0]               in_command,
  input  logic [15:0]              in_step_count,
  input  logic                     in_home_switch_a_n,
  input  logic                     in_home_switch_b_n,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_phase_a,
  output logic [1:0]               out_phase_b,
  output logic                     out_enable_a,
  output logic                     out_enable_b,
  output logic [2:0]               out_mode_a,
  output logic [2:0]               out_mode_b,
  output logic [15:0]              out_position_a,
  output logic [15:0]              out_position_b,
  output logic                     out_home_fault,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t res;
  cfg_t    cfg;
  logic    advance;
  logic    fire;

  assign advance  = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= '{opcode:       in_opcode,
                     motor_select: in_motor_select,
                     command:      in_command,
                     step_count:   in_step_count,
                     home_sw_n:    {in_home_switch_b_n, in_home_switch_a_n}};
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  dshs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dshs_motor_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (fire),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_valid      = out_valid_r;
  assign out_phase_a    = out_res_r.phase_a;
  assign out_phase_b    = out_res_r.phase_b;
  assign out_enable_a   = out_res_r.enable_a;
  assign out_enable_b   = out_res_r.enable_b;
  assign out_mode_a     = out_res_r.mode_a;
  assign out_mode_b     = out_res_r.mode_b;
  assign out_position_a = out_res_r.position_a;
  assign out_position_b = out_res_r.position_b;
  assign out_home_fault = out_res_r.home_fault;

endmodule
